>>> hdl/chained_hash_table_defines.svh
// Assertion macros shared by the chained hash table RTL.
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH
// Assert an implication on the rising clock edge, disabled in reset.
`define CHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert an implication in the next clock cycle, disabled in reset.
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> hdl/cht_pkg.sv
// Package with types, constants and the hash step function of the chained hash table.
`default_nettype none
package cht_pkg;
	localparam int BucketBits = 8;
	localparam int PoolEntries = 256;
	localparam logic [3:0] BucketLog2Reset = 4'd8;

	localparam logic [1:0] ActInsert = 2'd0;
	localparam logic [1:0] ActRemove = 2'd1;
	localparam logic [1:0] ActLookup = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [63:0] key;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic found;
		logic [63:0] result_value;
		logic status;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic [63:0] key;
	} hash_ctl_t;

	// One step of the Wang hash, selected by the step number.
	function automatic logic [63:0] wang_step(input logic [63:0] k, input logic [2:0] step);
		logic [63:0] r;
		case (step)
			3'd0: r = k + ~(k << 32);
			3'd1: r = k ^ (k >> 22);
			3'd2: r = k + ~(k << 13);
			3'd3: r = k ^ (k >> 8);
			3'd4: r = k + (k << 3);
			3'd5: r = k ^ (k >> 15);
			3'd6: r = k + ~(k << 27);
			default: r = k ^ (k >> 31);
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

>>> hdl/cht_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module cht_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] addr,
	input wire logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> hdl/cht_hash.sv
// Iterative Wang hash unit, one shift-and-combine step per cycle.
`default_nettype none
`include "chained_hash_table_defines.svh"
module cht_hash (
	input wire logic clk,
	input wire logic arst_n,
	input wire cht_pkg::hash_ctl_t ctl,
	output logic done,
	output logic [63:0] hash
);
	logic [63:0] k_q;
	logic [2:0] step_q;
	logic run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == 3'd7) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			k_q <= ctl.key;
		end else if (run_q) begin
			k_q <= cht_pkg::wang_step(k_q, step_q);
		end
	end

	assign done = run_q && (step_q == 3'd7);
	assign hash = cht_pkg::wang_step(k_q, step_q);

	`CHT_ASSERT_NEXT(a_done_ends_run, clk, arst_n, done && !ctl.start, !run_q, "hash run did not end")
	`CHT_ASSERT_NEXT(a_start_runs, clk, arst_n, ctl.start, run_q && step_q == 3'd0, "hash did not start")
	`CHT_ASSERT_IMP(a_done_in_run, clk, arst_n, done, run_q, "done outside run")
endmodule
`default_nettype wire

>>> hdl/chained_hash_table.sv
// Top level of the chained hash table with its sequencer and memories.
// After reset a clearing pass over the bucket heads and the pool links
// initializes the bucket heads and free list; busy stays high then.
// The key is hashed on the iterative hash unit and the bucket head is read
// (S_HASH, S_HEAD, S_HEADW); a refused insert, an empty bucket or an unused
// action ends there. An insert goes on through S_INS and S_INS2; a lookup
// walks the chain through S_RD, S_RDW and S_CMP per entry, and a remove that
// matches adds S_ULINK and S_FREE; busy is high until the return to S_IDLE.
// The result strobe comes in the first cycle busy is low, lasts one cycle and
// the receiver cannot stall it; a new request may be accepted in that cycle.
`default_nettype none
`include "chained_hash_table_defines.svh"
module chained_hash_table #(
	parameter int BUCKET_BITS = cht_pkg::BucketBits,
	parameter int POOL_ENTRIES = cht_pkg::PoolEntries
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire cht_pkg::req_t req,
	output logic busy,
	output logic done,
	output cht_pkg::rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [3:0] cfg_wdata
);
	localparam int NB = 1 << BUCKET_BITS;
	localparam int PW = $clog2(POOL_ENTRIES);
	localparam int LW = $clog2(POOL_ENTRIES + 1);
	localparam int CW = $clog2(((NB > POOL_ENTRIES) ? NB : POOL_ENTRIES) + 1);
	localparam logic [LW-1:0] Nil = LW'(POOL_ENTRIES);

	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001,
		S_IDLE  = 12'b000000000010,
		S_HASH  = 12'b000000000100,
		S_HEAD  = 12'b000000001000,
		S_HEADW = 12'b000000010000,
		S_RD    = 12'b000000100000,
		S_RDW   = 12'b000001000000,
		S_CMP   = 12'b000010000000,
		S_ULINK = 12'b000100000000,
		S_FREE  = 12'b001000000000,
		S_INS   = 12'b010000000000,
		S_INS2  = 12'b100000000000
	} state_t;

	state_t state_q;
	cht_pkg::req_t req_q;
	logic [3:0] log2_q;
	logic [BUCKET_BITS-1:0] bkt_q;
	logic [LW-1:0] cur_q, prev_q, free_q, next_q;
	logic [CW-1:0] cnt_q;
	logic [PW:0] steps_q;
	logic found_q, status_q;
	logic [63:0] rv_q;
	logic work_q;

	cht_pkg::hash_ctl_t hctl;
	logic hdone;
	logic [63:0] hval;

	logic hd_we, lk_we, kv_we;
	logic [BUCKET_BITS-1:0] hd_addr;
	logic [PW-1:0] lk_addr, kv_addr;
	logic [LW-1:0] hd_wdata, hd_rdata, lk_wdata, lk_rdata;
	logic [63:0] key_rdata, val_rdata;
	logic [BUCKET_BITS-1:0] mask;

	assign hctl.start = start && !busy;
	assign hctl.key = req.key;

	cht_hash u_hash (.clk(clk), .arst_n(arst_n), .ctl(hctl), .done(hdone), .hash(hval));

	cht_ram #(.Width(LW), .Depth(NB)) u_heads (.clk(clk), .we(hd_we), .addr(hd_addr),
		.wdata(hd_wdata), .rdata(hd_rdata));
	cht_ram #(.Width(LW), .Depth(POOL_ENTRIES)) u_links (.clk(clk), .we(lk_we),
		.addr(lk_addr), .wdata(lk_wdata), .rdata(lk_rdata));
	cht_ram #(.Width(64), .Depth(POOL_ENTRIES)) u_keys (.clk(clk), .we(kv_we),
		.addr(kv_addr), .wdata(req_q.key), .rdata(key_rdata));
	cht_ram #(.Width(64), .Depth(POOL_ENTRIES)) u_vals (.clk(clk), .we(kv_we),
		.addr(kv_addr), .wdata(req_q.value), .rdata(val_rdata));

	always_comb begin
		for (int i = 0; i < BUCKET_BITS; i++) begin
			mask[i] = (32'(i) < 32'(log2_q));
		end
	end

	always_comb begin
		hd_we = 1'b0;
		hd_addr = bkt_q;
		hd_wdata = next_q;
		lk_we = 1'b0;
		lk_addr = cur_q[PW-1:0];
		lk_wdata = next_q;
		kv_we = 1'b0;
		kv_addr = cur_q[PW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				hd_we = (cnt_q < CW'(NB));
				hd_addr = cnt_q[BUCKET_BITS-1:0];
				hd_wdata = Nil;
				lk_we = (cnt_q < CW'(POOL_ENTRIES));
				lk_addr = cnt_q[PW-1:0];
				lk_wdata = LW'(cnt_q) + LW'(1);
			end
			S_ULINK: begin
				if (prev_q != Nil) begin
					lk_we = 1'b1;
					lk_addr = prev_q[PW-1:0];
				end else begin
					hd_we = 1'b1;
				end
			end
			S_FREE: begin
				lk_we = 1'b1;
				lk_wdata = free_q;
			end
			S_INS: begin
				kv_we = 1'b1;
				lk_addr = free_q[PW-1:0];
			end
			S_INS2: begin
				lk_we = 1'b1;
				lk_wdata = hd_rdata;
				hd_we = 1'b1;
				hd_wdata = cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			free_q <= '0;
			log2_q <= cht_pkg::BucketLog2Reset;
			work_q <= 1'b0;
		end else begin
			work_q <= (state_q != S_IDLE) && (state_q != S_CLEAR);
			if (cfg_we) begin
				log2_q <= (int'(cfg_wdata) > BUCKET_BITS) ? 4'(BUCKET_BITS) : cfg_wdata;
			end
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(((NB > POOL_ENTRIES) ? NB : POOL_ENTRIES) - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: if (start) state_q <= S_HASH;
				S_HASH: if (hdone) state_q <= S_HEAD;
				S_HEAD: state_q <= S_HEADW;
				S_HEADW: begin
					if (req_q.action == cht_pkg::ActInsert) begin
						if (free_q == Nil) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_INS;
						end
					end else if (req_q.action == cht_pkg::ActRemove ||
							req_q.action == cht_pkg::ActLookup) begin
						if (hd_rdata == Nil) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RD: state_q <= S_RDW;
				S_RDW: state_q <= S_CMP;
				S_CMP: begin
					if (key_rdata == req_q.key) begin
						if (req_q.action == cht_pkg::ActLookup) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_ULINK;
						end
					end else if (lk_rdata == Nil ||
							steps_q == (PW+1)'(POOL_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_ULINK: state_q <= S_FREE;
				S_FREE: begin
					free_q <= cur_q;
					state_q <= S_IDLE;
				end
				S_INS: state_q <= S_INS2;
				S_INS2: begin
					free_q <= lk_rdata;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = (state_q == S_IDLE) && work_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q <= req;
				found_q <= 1'b0;
				status_q <= 1'b0;
				rv_q <= '0;
				prev_q <= Nil;
				steps_q <= '0;
			end
			S_HASH: bkt_q <= hval[BUCKET_BITS-1:0] & mask;
			S_HEADW: begin
				cur_q <= (req_q.action == cht_pkg::ActInsert) ? free_q : hd_rdata;
				status_q <= (req_q.action == cht_pkg::ActInsert) && (free_q == Nil);
			end
			S_CMP: begin
				next_q <= lk_rdata;
				if (key_rdata == req_q.key) begin
					found_q <= 1'b1;
					if (req_q.action == cht_pkg::ActLookup) begin
						rv_q <= val_rdata;
					end
				end else begin
					prev_q <= cur_q;
					cur_q <= lk_rdata;
					steps_q <= steps_q + (PW+1)'(1);
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	always_comb begin
		rsp.found = found_q;
		rsp.result_value = rv_q;
		rsp.status = status_q;
		if (state_q == S_CMP && key_rdata == req_q.key) begin
			rsp.found = 1'b1;
			if (req_q.action == cht_pkg::ActLookup) begin
				rsp.result_value = val_rdata;
			end
		end
		if (state_q == S_HEADW) begin
			rsp.status = (req_q.action == cht_pkg::ActInsert) && (free_q == Nil);
		end
	end

	`CHT_ASSERT_NEXT(a_done_one_cycle, clk, arst_n, done, !done, "result strobe too long")
	`CHT_ASSERT_IMP(a_accept_from_idle, clk, arst_n, start && !busy, state_q == S_IDLE, "accept outside idle")
	`CHT_ASSERT_IMP(a_free_range, clk, arst_n, state_q == S_IDLE, free_q <= Nil, "free head out of range")
	`CHT_ASSERT_IMP(a_status_insert, clk, arst_n, rsp.status && done, !rsp.found, "status with found")
endmodule
`default_nettype wire
